>>> rtl/core/emg_time_domain_features_unit_assert.svh
// ============================================================================
// EMG feature unit assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef EMG_TIME_DOMAIN_FEATURES_UNIT_ASSERT_SVH
`define EMG_TIME_DOMAIN_FEATURES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge.
`define EMG_TDF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");
// A consequence that must hold in the same cycle as its trigger.
`define EMG_TDF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
// A consequence that must hold in the cycle after its trigger.
`define EMG_TDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define EMG_TDF_ASSERT(lbl, prop)
`define EMG_TDF_ASSERT_IMPL(lbl, ante, cons)
`define EMG_TDF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/emg_tdf_pkg.sv
// ============================================================================
// EMG feature unit package
// Field widths, register codes and payload types shared by the feature unit.
// ============================================================================
package emg_tdf_pkg;

    localparam int CHANNEL_BITS   = 3;
    localparam int SAMPLE_BITS    = 16;
    localparam int LAG            = 2;
    localparam int TAPS           = 2 * LAG;
    localparam int WINDOW_MAX     = 256;
    localparam int POS_BITS       = 9;
    localparam int SUM_BITS       = 24;
    localparam int LEN_BITS       = 25;
    localparam int COUNT_BITS     = 9;
    localparam int LEVEL_BITS     = 15;
    localparam int RECIP_BITS     = 24;
    localparam int RATE_BITS      = 16;

    // Right shifts that bring each product back to its output format.
    localparam int MEAN_SHIFT     = 24;
    localparam int LEN_SHIFT      = 25;
    localparam int RATE_SHIFT     = 8;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADZONE          = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_THRESHOLD    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_RECIPROCAL = 2'd2;

    localparam logic [LEVEL_BITS-1:0] DEADZONE_RESET       = 15'd33;
    localparam logic [LEVEL_BITS-1:0] TURN_THRESHOLD_RESET = 15'd49;
    localparam logic [RECIP_BITS-1:0] RECIPROCAL_RESET     = 24'd111848;

    localparam int RESULT_DEPTH   = 4;
    localparam int RESULT_PTR_BITS = 2;
    localparam int RESULT_CNT_BITS = 3;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]       channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } sample_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]       out_channel;
        logic signed [SAMPLE_BITS-1:0] mean_value;
        logic [RATE_BITS-1:0]          length_rate;
        logic [RATE_BITS-1:0]          zero_rate;
        logic [RATE_BITS-1:0]          turn_rate;
        logic [COUNT_BITS-1:0]         zero_total;
        logic [COUNT_BITS-1:0]         turn_total;
    } feature_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] deadzone;
        logic [LEVEL_BITS-1:0] turn_threshold;
        logic [RECIP_BITS-1:0] window_reciprocal;
    } cfg_t;

    // One channel's entry of the state memory; taps[0] is the newest sample.
    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_BITS-1:0] taps;
        logic signed [SUM_BITS-1:0]       sum;
        logic [LEN_BITS-1:0]              length;
        logic [COUNT_BITS-1:0]            crossings;
        logic [COUNT_BITS-1:0]            turns;
        logic [POS_BITS-1:0]              position;
    } state_t;

    // Accumulated totals of a closed window, before scaling.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0]    channel;
        logic signed [SUM_BITS-1:0] sum;
        logic [LEN_BITS-1:0]        length;
        logic [COUNT_BITS-1:0]      crossings;
        logic [COUNT_BITS-1:0]      turns;
    } window_t;

endpackage

>>> rtl/core/emg_tdf_state_mem.sv
// ============================================================================
// EMG feature unit state memory
// Per-channel state store with registered read, entry valid bits and a
// one-entry forward of the most recent write.
// ============================================================================
module emg_tdf_state_mem #(
    parameter int CHANNELS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   rd_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_index,
    input  logic                                   wr_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_index,
    input  emg_tdf_pkg::state_t                    wr_data,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] cur_index,
    output emg_tdf_pkg::state_t                    state
);

    localparam int INDEX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    emg_tdf_pkg::state_t   mem [CHANNELS];
    logic [CHANNELS-1:0]   written_reg;
    emg_tdf_pkg::state_t   rd_data_reg;
    logic                  rd_written_reg;
    emg_tdf_pkg::state_t   fwd_data_reg;
    logic [INDEX_BITS-1:0] fwd_index_reg;
    logic                  fwd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_index] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_data_reg  <= wr_data;
            fwd_index_reg <= wr_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_index] <= 1'b1;
                fwd_valid_reg         <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_index];
            end
        end
    end

    // A read that races the write at the same edge returns the old entry, so the
    // last written value wins whenever it belongs to the same channel.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_index_reg == cur_index))
        begin
            state = fwd_data_reg;
        end
        else if (rd_written_reg)
        begin
            state = rd_data_reg;
        end
        else
        begin
            state = '0;
        end
    end

endmodule

>>> rtl/core/emg_tdf_update.sv
// ============================================================================
// EMG feature unit state update
// Folds one sample into its channel's state: sum, waveform length, zero
// crossings, slope turns, delay line and position.
// ============================================================================
module emg_tdf_update (
    input  emg_tdf_pkg::state_t  state,
    input  emg_tdf_pkg::sample_t item,
    input  emg_tdf_pkg::cfg_t    cfg,
    output emg_tdf_pkg::state_t  state_next,
    output emg_tdf_pkg::window_t window
);

    localparam int SB   = emg_tdf_pkg::SAMPLE_BITS;
    localparam int SUMB = emg_tdf_pkg::SUM_BITS;
    localparam int LENB = emg_tdf_pkg::LEN_BITS;
    localparam int LVB  = emg_tdf_pkg::LEVEL_BITS;
    localparam int TAPS = emg_tdf_pkg::TAPS;
    localparam int LAG  = emg_tdf_pkg::LAG;
    localparam int PB   = emg_tdf_pkg::POS_BITS;

    logic signed [SB-1:0]   x;
    logic signed [SB-1:0]   fst;
    logic signed [SB-1:0]   mid;
    logic signed [SB:0]     x_w;
    logic signed [SB:0]     fst_w;
    logic signed [SB:0]     mid_w;
    logic signed [SB:0]     dz_w;
    logic signed [SB:0]     diff_mf;
    logic signed [SB:0]     diff_ml;
    logic [SB:0]            step_mf;
    logic [SB:0]            step_ml;
    logic [SB:0]            th_w;
    logic signed [SUMB:0]   sum_wide;
    logic signed [SUMB-1:0] sum_sat;
    logic [LENB:0]          len_wide;
    logic [LENB-1:0]        len_sat;
    logic                   lag_on;
    logic                   same_sign;
    logic                   quiet;
    logic                   extremum;
    logic                   steep;
    emg_tdf_pkg::state_t    updated;

    assign x     = item.sample;
    assign fst   = $signed(state.taps[TAPS-1]);
    assign mid   = $signed(state.taps[LAG-1]);
    assign x_w   = (SB+1)'(x);
    assign fst_w = (SB+1)'(fst);
    assign mid_w = (SB+1)'(mid);
    assign dz_w  = $signed({{(SB+1-LVB){1'b0}}, cfg.deadzone});
    assign th_w  = {{(SB+1-LVB){1'b0}}, cfg.turn_threshold};

    assign lag_on = state.position >= PB'(TAPS);

    assign sum_wide = (SUMB+1)'(state.sum) + (SUMB+1)'(x);
    always_comb
    begin
        if (sum_wide[SUMB] != sum_wide[SUMB-1])
        begin
            sum_sat = sum_wide[SUMB] ? {1'b1, {(SUMB-1){1'b0}}} : {1'b0, {(SUMB-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUMB-1:0];
        end
    end

    // Zero is on both sides, so a step to or from zero is no crossing.
    assign same_sign = (!mid[SB-1] && !fst[SB-1]) ||
                       ((mid[SB-1] || (mid == '0)) && (fst[SB-1] || (fst == '0)));
    assign quiet = (mid_w < dz_w) && (mid_w > -dz_w) && (fst_w < dz_w) && (fst_w > -dz_w);

    assign diff_mf  = mid_w - fst_w;
    assign diff_ml  = mid_w - x_w;
    assign step_mf  = diff_mf[SB] ? $unsigned(-diff_mf) : $unsigned(diff_mf);
    assign step_ml  = diff_ml[SB] ? $unsigned(-diff_ml) : $unsigned(diff_ml);
    assign extremum = ((mid > fst) && (mid > x)) || ((mid < fst) && (mid < x));
    assign steep    = (step_mf > th_w) || (step_ml > th_w);

    assign len_wide = {1'b0, state.length} + (LENB+1)'(step_mf);
    assign len_sat  = len_wide[LENB] ? '1 : len_wide[LENB-1:0];

    always_comb
    begin
        updated     = state;
        updated.sum = sum_sat;
        if (lag_on)
        begin
            if (!same_sign && !quiet && (state.crossings != '1))
            begin
                updated.crossings = state.crossings + 1'b1;
            end
            if (extremum && steep && (state.turns != '1))
            begin
                updated.turns = state.turns + 1'b1;
            end
            updated.length = len_sat;
        end
        for (int k = TAPS - 1; k > 0; k--)
        begin
            updated.taps[k] = state.taps[k-1];
        end
        updated.taps[0] = item.sample;
        if (state.position != PB'(emg_tdf_pkg::WINDOW_MAX))
        begin
            updated.position = state.position + 1'b1;
        end
    end

    // A closing sample hands its totals on and leaves the channel cleared.
    assign state_next = item.last_sample ? '0 : updated;

    assign window.channel   = item.channel;
    assign window.sum       = updated.sum;
    assign window.length    = updated.length;
    assign window.crossings = updated.crossings;
    assign window.turns     = updated.turns;

endmodule

>>> rtl/core/emg_tdf_scale.sv
// ============================================================================
// EMG feature unit scaling stage
// Registers the window totals, then multiplies them by the window reciprocal
// and rounds and saturates the products into the feature record.
// ============================================================================
module emg_tdf_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  emg_tdf_pkg::window_t   window,
    input  emg_tdf_pkg::cfg_t      cfg,
    output logic                   result_valid,
    output emg_tdf_pkg::feature_t  result
);

    localparam int SB   = emg_tdf_pkg::SAMPLE_BITS;
    localparam int RB   = emg_tdf_pkg::RECIP_BITS;
    localparam int CB   = emg_tdf_pkg::COUNT_BITS;
    localparam int QB   = emg_tdf_pkg::RATE_BITS;
    localparam int MS   = emg_tdf_pkg::MEAN_SHIFT;
    localparam int LS   = emg_tdf_pkg::LEN_SHIFT;
    localparam int RS   = emg_tdf_pkg::RATE_SHIFT;
    localparam int PMB  = emg_tdf_pkg::SUM_BITS + RB + 1;
    localparam int PLB  = emg_tdf_pkg::LEN_BITS + RB;
    localparam int PCB  = CB + RB;
    localparam int MSB_BITS = PMB + 1 - MS;

    localparam logic signed [PMB:0] MEAN_HALF = (PMB+1)'(64'sd1 <<< (MS - 1));
    localparam logic [PLB:0]        LEN_HALF  = (PLB+1)'(64'd1 << (LS - 1));
    localparam logic [PCB:0]        RATE_HALF = (PCB+1)'(64'd1 << (RS - 1));
    localparam logic signed [MSB_BITS-1:0] MEAN_HI = MSB_BITS'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [MSB_BITS-1:0] MEAN_LO = MSB_BITS'(-(64'sd1 <<< (SB - 1)));

    logic                                     valid_reg;
    logic [emg_tdf_pkg::CHANNEL_BITS-1:0]     channel_reg;
    logic signed [emg_tdf_pkg::SUM_BITS-1:0]  sum_reg;
    logic [emg_tdf_pkg::LEN_BITS-1:0]         length_reg;
    logic [CB-1:0]                            crossings_reg;
    logic [CB-1:0]                            turns_reg;

    logic signed [PMB-1:0]                    prod_mean;
    logic [PLB-1:0]                           prod_len;
    logic [PCB-1:0]                           prod_zero;
    logic [PCB-1:0]                           prod_turn;

    logic signed [PMB:0]                      mean_round;
    logic signed [MSB_BITS-1:0]               mean_shift;
    logic [PLB:0]                             len_round;

    function automatic logic [QB-1:0] count_rate(input logic [PCB-1:0] prod);
        logic [PCB:0] rounded;
        rounded = (PCB+1)'(prod) + RATE_HALF;
        return (|rounded[PCB:RS+QB]) ? '1 : rounded[RS+QB-1:RS];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            channel_reg   <= window.channel;
            sum_reg       <= window.sum;
            length_reg    <= window.length;
            crossings_reg <= window.crossings;
            turns_reg     <= window.turns;
        end
    end

    // The multipliers start from registered totals, away from the state update.
    assign prod_mean = sum_reg * $signed({1'b0, cfg.window_reciprocal});
    assign prod_len  = length_reg * cfg.window_reciprocal;
    assign prod_zero = crossings_reg * cfg.window_reciprocal;
    assign prod_turn = turns_reg * cfg.window_reciprocal;

    // The arithmetic shift of the biased product floors toward minus infinity.
    assign mean_round = (PMB+1)'(prod_mean) + MEAN_HALF;
    assign mean_shift = $signed(mean_round[PMB:MS]);
    assign len_round  = (PLB+1)'(prod_len) + LEN_HALF;

    assign result_valid       = valid_reg;
    assign result.out_channel = channel_reg;
    assign result.zero_total  = crossings_reg;
    assign result.turn_total  = turns_reg;
    assign result.zero_rate   = count_rate(prod_zero);
    assign result.turn_rate   = count_rate(prod_turn);

    always_comb
    begin
        if (mean_shift > MEAN_HI)
        begin
            result.mean_value = {1'b0, {(SB-1){1'b1}}};
        end
        else if (mean_shift < MEAN_LO)
        begin
            result.mean_value = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            result.mean_value = mean_shift[SB-1:0];
        end
    end

    assign result.length_rate = (|len_round[PLB:LS+QB]) ? '1 : len_round[LS+QB-1:LS];

endmodule

>>> rtl/core/emg_tdf_result_fifo.sv
// ============================================================================
// EMG feature unit result queue
// Small first-in first-out queue of finished feature records in front of
// the output port.
// ============================================================================
module emg_tdf_result_fifo (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    input  emg_tdf_pkg::feature_t                       push_data,
    input  logic                                        pop,
    output logic                                        head_valid,
    output emg_tdf_pkg::feature_t                       head_data,
    output logic [emg_tdf_pkg::RESULT_CNT_BITS-1:0]     count
);

    localparam int PTRB = emg_tdf_pkg::RESULT_PTR_BITS;
    localparam int CNTB = emg_tdf_pkg::RESULT_CNT_BITS;

    emg_tdf_pkg::feature_t entries [emg_tdf_pkg::RESULT_DEPTH];
    logic [PTRB-1:0]       wr_ptr_reg;
    logic [PTRB-1:0]       rd_ptr_reg;
    logic [CNTB-1:0]       count_reg;
    logic [CNTB-1:0]       count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_data  = entries[rd_ptr_reg];
    assign count      = count_reg;

endmodule

>>> rtl/core/emg_time_domain_features_unit.sv
// ============================================================================
// EMG time-domain feature unit
// Per-channel mean, waveform length, zero-crossing and slope-turn features
// over sample windows of an interleaved multichannel stream.
// ============================================================================
//
// Channel   Dir  Handshake                    Payload
// sample    in   sample_valid / sample_stall  emg_tdf_pkg::sample_t
// feature   out  feature_valid / feature_stall emg_tdf_pkg::feature_t
// cfg       in   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One sample request is taken every cycle while sample_stall is low; each one in
// range takes one read and one write of the single state memory, and a forward
// of the last write covers a channel hit in consecutive cycles.
// A closing sample's record passes the s1 register, scaling register and queue.
// sample_stall rises while four results sit in the update stage, the scaling
// stage and the four-entry result queue together; feature_stall never blocks
// state updates directly.
// After reset every channel reads as cleared through per-entry valid bits, so
// requests are taken from the first cycle with no clearing pass.
// ============================================================================
`include "emg_time_domain_features_unit_assert.svh"

module emg_time_domain_features_unit #(
    parameter int CHANNELS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  emg_tdf_pkg::sample_t                    sample_data,
    output logic                                    feature_valid,
    input  logic                                    feature_stall,
    output emg_tdf_pkg::feature_t                   feature_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [emg_tdf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [emg_tdf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int INDEX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_BITS   = (INDEX_BITS > emg_tdf_pkg::CHANNEL_BITS) ?
                                INDEX_BITS : emg_tdf_pkg::CHANNEL_BITS;
    localparam int CNTB       = emg_tdf_pkg::RESULT_CNT_BITS;
    localparam logic [CNTB-1:0] FULL = CNTB'(emg_tdf_pkg::RESULT_DEPTH);

    emg_tdf_pkg::cfg_t     cfg_reg;
    logic                  sample_accept;
    logic                  in_range;
    logic [EXT_BITS-1:0]   channel_ext;
    logic [INDEX_BITS-1:0] rd_index;

    logic                  s1_valid_reg;
    emg_tdf_pkg::sample_t  s1_item_reg;
    logic [INDEX_BITS-1:0] s1_index_reg;

    emg_tdf_pkg::state_t   cur_state;
    emg_tdf_pkg::state_t   new_state;
    emg_tdf_pkg::window_t  window;
    logic                  s1_closing;

    logic                  scale_valid;
    emg_tdf_pkg::feature_t scale_result;
    logic                  feature_pop;
    logic [CNTB-1:0]       fifo_count;
    logic [CNTB-1:0]       pending;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadzone          <= emg_tdf_pkg::DEADZONE_RESET;
            cfg_reg.turn_threshold    <= emg_tdf_pkg::TURN_THRESHOLD_RESET;
            cfg_reg.window_reciprocal <= emg_tdf_pkg::RECIPROCAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                emg_tdf_pkg::CFG_DEADZONE:
                begin
                    cfg_reg.deadzone <= cfg_data[emg_tdf_pkg::LEVEL_BITS-1:0];
                end
                emg_tdf_pkg::CFG_TURN_THRESHOLD:
                begin
                    cfg_reg.turn_threshold <= cfg_data[emg_tdf_pkg::LEVEL_BITS-1:0];
                end
                emg_tdf_pkg::CFG_WINDOW_RECIPROCAL:
                begin
                    cfg_reg.window_reciprocal <= cfg_data[emg_tdf_pkg::RECIP_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Input side: samples of channels the memory does not hold are dropped here.
    assign sample_accept = sample_valid && !sample_stall;
    assign in_range      = 32'(sample_data.channel) < CHANNELS;
    assign channel_ext   = EXT_BITS'(sample_data.channel);
    assign rd_index      = channel_ext[INDEX_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= sample_accept && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_item_reg  <= sample_data;
            s1_index_reg <= rd_index;
        end
    end

    emg_tdf_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_state_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (sample_accept && in_range),
        .rd_index  (rd_index),
        .wr_en     (s1_valid_reg),
        .wr_index  (s1_index_reg),
        .wr_data   (new_state),
        .cur_index (s1_index_reg),
        .state     (cur_state)
    );

    emg_tdf_update u_update (
        .state      (cur_state),
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .state_next (new_state),
        .window     (window)
    );

    assign s1_closing = s1_valid_reg && s1_item_reg.last_sample;

    emg_tdf_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (s1_closing),
        .window       (window),
        .cfg          (cfg_reg),
        .result_valid (scale_valid),
        .result       (scale_result)
    );

    assign feature_pop = feature_valid && !feature_stall;

    emg_tdf_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (scale_valid),
        .push_data  (scale_result),
        .pop        (feature_pop),
        .head_valid (feature_valid),
        .head_data  (feature_data),
        .count      (fifo_count)
    );

    // Every result in flight has a queue slot reserved, so the stages after the
    // memory never need to hold.
    assign pending      = CNTB'(s1_closing) + CNTB'(scale_valid) + fifo_count;
    assign sample_stall = pending >= FULL;

    `EMG_TDF_ASSERT(a_credit_bound, pending <= FULL)
    `EMG_TDF_ASSERT_IMPL(a_s1_in_range, s1_valid_reg, 32'(s1_item_reg.channel) < CHANNELS)
    `EMG_TDF_ASSERT_NEXT(a_close_to_scale, s1_closing, scale_valid)
    `EMG_TDF_ASSERT_IMPL(a_no_queue_overrun, scale_valid, (fifo_count != FULL) || feature_pop)

endmodule
